// ===== rtl/mtu_pkg.sv =====
// Shared types, codes and status decoders for the MIDI to USB-MIDI packetiser.
`default_nettype none
package mtu_pkg;

  // Status bytes of interest
  localparam logic [7:0] RT_FIRST       = 8'hF8;
  localparam logic [7:0] ST_SYSEX_START = 8'hF0;
  localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
  localparam logic [7:0] ST_MTC_QFRAME  = 8'hF1;
  localparam logic [7:0] ST_SONG_SELECT = 8'hF3;
  localparam logic [7:0] ST_SONG_POS    = 8'hF2;
  localparam logic [7:0] ST_TUNE_REQ    = 8'hF6;
  localparam logic [7:0] ST_SYS_COMMON  = 8'hF0;
  localparam logic [7:0] TYPE_PROG_CHG  = 8'hC0;
  localparam logic [7:0] TYPE_CHAN_PRES = 8'hD0;
  localparam logic [7:0] TYPE_MASK      = 8'hF0;

  // Code index numbers
  localparam logic [3:0] CIN_SC_TWO     = 4'h2;
  localparam logic [3:0] CIN_SC_THREE   = 4'h3;
  localparam logic [3:0] CIN_SYSEX_CONT = 4'h4;
  localparam logic [3:0] CIN_SYSEX_END1 = 4'h5;
  localparam logic [3:0] CIN_SINGLE     = 4'hF;

  localparam logic [1:0] LEN_ONE   = 2'd1;
  localparam logic [1:0] LEN_TWO   = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

  typedef enum logic [1:0] {
    KIND_PACKET      = 2'd0,
    KIND_FINISH_OK   = 2'd1,
    KIND_UNTERM_SYSX = 2'd2,
    KIND_INCOMPLETE  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [3:0] code_index;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic [7:0] byte_three;
  } result_t;

  // Total message length, status included, for 0x80..0xF7
  function automatic logic [1:0] full_length(input logic [7:0] st);
    logic [1:0] len;
    begin
      len = LEN_ONE;
      if (st < ST_SYS_COMMON) begin
        if ((st & TYPE_MASK) == TYPE_PROG_CHG || (st & TYPE_MASK) == TYPE_CHAN_PRES) begin
          len = LEN_TWO;
        end else begin
          len = LEN_THREE;
        end
      end else if (st == ST_MTC_QFRAME || st == ST_SONG_SELECT) begin
        len = LEN_TWO;
      end else if (st == ST_SONG_POS) begin
        len = LEN_THREE;
      end
      return len;
    end
  endfunction

  function automatic logic [3:0] code_for_status(input logic [7:0] st);
    logic [3:0] cin;
    begin
      cin = CIN_SINGLE;
      if (st[7] && st < ST_SYS_COMMON) begin
        cin = st[7:4];
      end else if (st == ST_MTC_QFRAME || st == ST_SONG_SELECT) begin
        cin = CIN_SC_TWO;
      end else if (st == ST_SONG_POS) begin
        cin = CIN_SC_THREE;
      end else if (st == ST_TUNE_REQ || st == ST_SYSEX_END) begin
        cin = CIN_SYSEX_END1;
      end
      return cin;
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mtu_engine.sv =====
// Packet assembly state and per-word encode logic.
`default_nettype none
module mtu_engine (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic             cmd_i,
  input  wire logic [7:0]       midi_byte_i,
  output logic                  res_vld_o,
  output mtu_pkg::result_t      res_o
);

  logic       in_sysex_q, in_sysex_d;
  logic [7:0] held0_q, held0_d;
  logic [7:0] held1_q, held1_d;
  logic [1:0] held_cnt_q, held_cnt_d;
  logic [7:0] msg_status_q, msg_status_d;
  logic [7:0] msg_data_q, msg_data_d;
  logic [1:0] msg_cnt_q, msg_cnt_d;
  logic [1:0] msg_needed_q, msg_needed_d;

  logic [1:0] len;
  logic [2:0] cnt_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sysex_q   <= 1'b0;
      held0_q      <= '0;
      held1_q      <= '0;
      held_cnt_q   <= '0;
      msg_status_q <= '0;
      msg_data_q   <= '0;
      msg_cnt_q    <= '0;
      msg_needed_q <= '0;
    end else begin
      in_sysex_q   <= in_sysex_d;
      held0_q      <= held0_d;
      held1_q      <= held1_d;
      held_cnt_q   <= held_cnt_d;
      msg_status_q <= msg_status_d;
      msg_data_q   <= msg_data_d;
      msg_cnt_q    <= msg_cnt_d;
      msg_needed_q <= msg_needed_d;
    end
  end

  assign len      = mtu_pkg::full_length(midi_byte_i);
  assign cnt_next = {1'b0, msg_cnt_q} + 3'd1;

  always_comb begin
    in_sysex_d   = in_sysex_q;
    held0_d      = held0_q;
    held1_d      = held1_q;
    held_cnt_d   = held_cnt_q;
    msg_status_d = msg_status_q;
    msg_data_d   = msg_data_q;
    msg_cnt_d    = msg_cnt_q;
    msg_needed_d = msg_needed_q;
    res_vld_o    = 1'b0;
    res_o        = '{kind: mtu_pkg::KIND_PACKET, code_index: 4'h0,
                     byte_one: 8'h00, byte_two: 8'h00, byte_three: 8'h00};

    if (step_i) begin
      if (cmd_i) begin
        // finish: report and clear everything
        res_vld_o = 1'b1;
        if (in_sysex_q) begin
          res_o.kind = mtu_pkg::KIND_UNTERM_SYSX;
        end else if (msg_cnt_q != 2'd0) begin
          res_o.kind = mtu_pkg::KIND_INCOMPLETE;
        end else begin
          res_o.kind = mtu_pkg::KIND_FINISH_OK;
        end
        in_sysex_d   = 1'b0;
        held0_d      = '0;
        held1_d      = '0;
        held_cnt_d   = '0;
        msg_status_d = '0;
        msg_data_d   = '0;
        msg_cnt_d    = '0;
        msg_needed_d = '0;
      end else if (midi_byte_i >= mtu_pkg::RT_FIRST) begin
        // real-time passes straight through, state untouched
        res_vld_o        = 1'b1;
        res_o.code_index = mtu_pkg::CIN_SINGLE;
        res_o.byte_one   = midi_byte_i;
      end else if (in_sysex_q) begin
        if (midi_byte_i == mtu_pkg::ST_SYSEX_END) begin
          res_vld_o        = 1'b1;
          res_o.code_index = mtu_pkg::CIN_SYSEX_END1 + {2'b00, held_cnt_q};
          case (held_cnt_q)
            2'd0: begin
              res_o.byte_one = midi_byte_i;
            end
            2'd1: begin
              res_o.byte_one = held0_q;
              res_o.byte_two = midi_byte_i;
            end
            default: begin
              res_o.byte_one   = held0_q;
              res_o.byte_two   = held1_q;
              res_o.byte_three = midi_byte_i;
            end
          endcase
          held0_d    = '0;
          held1_d    = '0;
          held_cnt_d = '0;
          in_sysex_d = 1'b0;
        end else if (held_cnt_q == 2'd2) begin
          res_vld_o        = 1'b1;
          res_o.code_index = mtu_pkg::CIN_SYSEX_CONT;
          res_o.byte_one   = held0_q;
          res_o.byte_two   = held1_q;
          res_o.byte_three = midi_byte_i;
          held0_d          = '0;
          held1_d          = '0;
          held_cnt_d       = '0;
        end else begin
          if (held_cnt_q == 2'd0) begin
            held0_d = midi_byte_i;
          end else begin
            held1_d = midi_byte_i;
          end
          held_cnt_d = held_cnt_q + 2'd1;
        end
      end else if (midi_byte_i == mtu_pkg::ST_SYSEX_START) begin
        msg_cnt_d    = '0;
        msg_needed_d = '0;
        msg_status_d = '0;
        msg_data_d   = '0;
        held0_d      = midi_byte_i;
        held1_d      = '0;
        held_cnt_d   = 2'd1;
        in_sysex_d   = 1'b1;
      end else if (midi_byte_i[7]) begin
        // new status drops whatever was pending
        msg_data_d = '0;
        if (len == mtu_pkg::LEN_ONE) begin
          msg_cnt_d        = '0;
          msg_needed_d     = '0;
          msg_status_d     = '0;
          res_vld_o        = 1'b1;
          res_o.code_index = mtu_pkg::code_for_status(midi_byte_i);
          res_o.byte_one   = midi_byte_i;
        end else begin
          msg_status_d = midi_byte_i;
          msg_cnt_d    = 2'd1;
          msg_needed_d = len;
        end
      end else if (msg_cnt_q != 2'd0) begin
        if (cnt_next >= {1'b0, msg_needed_q}) begin
          res_vld_o        = 1'b1;
          res_o.code_index = mtu_pkg::code_for_status(msg_status_q);
          res_o.byte_one   = msg_status_q;
          if (msg_cnt_q == 2'd1) begin
            res_o.byte_two = midi_byte_i;
          end else begin
            res_o.byte_two   = msg_data_q;
            res_o.byte_three = midi_byte_i;
          end
          msg_cnt_d    = '0;
          msg_needed_d = '0;
          msg_status_d = '0;
          msg_data_d   = '0;
        end else begin
          msg_data_d = midi_byte_i;
          msg_cnt_d  = 2'd2;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && cmd_i |=> !in_sysex_q && held_cnt_q == 2'd0 && msg_cnt_q == 2'd0)
    else $error("finish did not clear state");
  a_sysex_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_sysex_q |-> msg_cnt_q == 2'd0)
    else $error("message pending inside sysex");
  a_held_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_sysex_q |-> held_cnt_q == 2'd0)
    else $error("sysex bytes held outside sysex");
`endif

endmodule
`default_nettype wire

// ===== rtl/midi_to_usb_event_packetizer_core.sv =====
// Top level: input word register, encode engine and output result register.
`default_nettype none
// Turns a stream of raw MIDI bytes into USB-MIDI event packets on cable 0.
// Each input word is either a MIDI byte (cmd 0) or a finish command (cmd 1);
// each yields at most one result word: a packet (code index plus three bytes,
// unused bytes zero) or a finish status, after which all state is cleared.
// Running status is not handled and stray data bytes are dropped; on an
// error status the receiver must discard the packets since the last finish.
// One word is taken per cycle while the input is not stalled. Each word
// waits in the input register while the engine encodes it, and the result
// register takes the outcome when the pipe advances. A stalled result holds
// the input register, so the input stalls only while both registers are
// full and the output stalls.
module midi_to_usb_event_packetizer_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       cmd_i,
  input  wire logic [7:0] midi_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      kind_o,
  output logic [3:0]      code_index_o,
  output logic [7:0]      byte_one_o,
  output logic [7:0]      byte_two_o,
  output logic [7:0]      byte_three_o
);

  logic             in_vld_q, in_vld_d;
  logic             cmd_q;
  logic [7:0]       byte_q;
  logic             out_vld_q, out_vld_d;
  mtu_pkg::result_t res_q;
  mtu_pkg::result_t res;
  logic             res_vld;
  logic             adv;
  logic             in_take;

  // whole pipe moves when the result register is free or being drained
  assign adv        = !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  assign in_vld_d  = in_take ? 1'b1 : (adv ? 1'b0 : in_vld_q);
  assign out_vld_d = adv ? (in_vld_q && res_vld) : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q  <= cmd_i;
      byte_q <= midi_byte_i;
    end
    if (adv && in_vld_q && res_vld) begin
      res_q <= res;
    end
  end

  mtu_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_vld_q && adv),
    .cmd_i       (cmd_q),
    .midi_byte_i (byte_q),
    .res_vld_o   (res_vld),
    .res_o       (res)
  );

  assign out_valid_o  = out_vld_q;
  assign kind_o       = res_q.kind;
  assign code_index_o = res_q.code_index;
  assign byte_one_o   = res_q.byte_one;
  assign byte_two_o   = res_q.byte_two;
  assign byte_three_o = res_q.byte_three;

`ifndef NO_ASSERTIONS
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> !in_stall_o)
    else $error("input stalled with empty result register");
  a_finish_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && adv && cmd_q |=> out_vld_q)
    else $error("finish word produced no result");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i |=> out_vld_q && $stable(res_q))
    else $error("stalled result word changed");
`endif

endmodule
`default_nettype wire
